// ===== sv/kgte_pkg.sv =====
package kgte_pkg;

   localparam logic [1:0] ACTION_CLEAR = 2'd0;
   localparam logic [1:0] ACTION_ADD   = 2'd1;
   localparam logic [1:0] ACTION_EVAL  = 2'd2;

   localparam logic [7:0] EMPTY_VALUE = 8'd255;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] point_tick;
      logic [7:0]         point_value;
   } req_type;

   typedef struct packed {
      logic [7:0] track_value;
      logic       add_rejected;
      logic [5:0] point_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] tick;
      logic [7:0]         value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_READ,
      ST_ADD_CMP,
      ST_EVAL_READ,
      ST_EVAL_CMP,
      ST_DIV,
      ST_BLEND,
      ST_DONE
   } state_type;

endpackage

// ===== sv/keyframe_gradient_track_evaluator.sv =====
// Keyframe track evaluator: holds up to MAX_POINTS tick-sorted control points in a
// table memory with one write port and a registered read port, and handles one request
// at a time. A clear, an unknown action, an add to a full table or an evaluate of an
// empty table goes straight to the done state. Any other add walks down from the top
// of the table, one read and one move per held point with a tick above the new one.
// An evaluate either clamps at point r or interpolates between points r-1 and r;
// the fraction comes from a restoring divider that yields one quotient bit per cycle.
// A finished result sits in the response register, and the next request can be taken
// while it waits.
module keyframe_gradient_track_evaluator #(
   parameter int MAX_POINTS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kgte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kgte_pkg::rsp_type rsp_data
);

   localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int QW  = FRACTION_BITS + 1;
   localparam int DCW = $clog2(FRACTION_BITS + 1);
   localparam int PW  = FRACTION_BITS + 11;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_POINTS);

   kgte_pkg::state_type state_ff, state_in;

   kgte_pkg::entry_type table_mem [MAX_POINTS];
   kgte_pkg::entry_type rd_data_ff;
   logic [IW-1:0]       rd_addr;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   kgte_pkg::entry_type wr_data;

   kgte_pkg::req_type req_ff, req_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic signed [31:0] prev_tick_ff, prev_tick_in;
   logic [7:0]        prev_value_ff, prev_value_in;
   logic [7:0]        next_value_ff, next_value_in;
   logic [31:0]       dist_ff, dist_in;
   logic [32:0]       rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [DCW-1:0]    div_cnt_ff, div_cnt_in;
   logic [7:0]        track_ff, track_in;
   logic              rej_ff, rej_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kgte_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              hit;
   logic              last_entry;
   logic              rsp_free;
   logic [32:0]       rem_sub;
   logic              rem_ge;
   logic [32:0]       rem_sel;
   logic [32:0]       dx_full;
   logic [32:0]       dist_full;
   logic signed [8:0] vdiff;
   logic signed [PW-1:0] diff_w, quo_w, base_w, half_w, acc_w;
   logic [CW+5:0]     count_wide;

   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign hit        = $signed(rd_data_ff.tick) >= $signed(req_ff.point_tick);
   assign last_entry = (idx_ff + CW'(1)) == count_ff;

   assign rem_sub = rem_ff - {1'b0, dist_ff};
   assign rem_ge  = rem_ff >= {1'b0, dist_ff};
   assign rem_sel = rem_ge ? rem_sub : rem_ff;

   assign dx_full   = 33'($signed(req_ff.point_tick)) - 33'($signed(prev_tick_ff));
   assign dist_full = 33'($signed(rd_data_ff.tick)) - 33'($signed(prev_tick_ff));

   assign vdiff  = $signed({1'b0, next_value_ff}) - $signed({1'b0, prev_value_ff});
   assign diff_w = PW'(vdiff);
   assign quo_w  = PW'($signed({1'b0, quo_ff}));
   assign base_w = PW'($signed({1'b0, prev_value_ff, {FRACTION_BITS{1'b0}}}));
   assign half_w = PW'(1) <<< (FRACTION_BITS - 1);
   assign acc_w  = base_w + diff_w * quo_w + half_w;

   assign count_wide = {6'd0, count_in};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kgte_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  kgte_pkg::ACTION_ADD: begin
                     state_in = (count_ff >= MAX_COUNT) ? kgte_pkg::ST_DONE
                                                        : kgte_pkg::ST_ADD_READ;
                  end
                  kgte_pkg::ACTION_EVAL: begin
                     state_in = (count_ff == '0) ? kgte_pkg::ST_DONE
                                                 : kgte_pkg::ST_EVAL_READ;
                  end
                  default: state_in = kgte_pkg::ST_DONE;
               endcase
            end
         end
         kgte_pkg::ST_ADD_READ: begin
            state_in = (idx_ff == '0) ? kgte_pkg::ST_DONE : kgte_pkg::ST_ADD_CMP;
         end
         kgte_pkg::ST_ADD_CMP: begin
            state_in = ($signed(rd_data_ff.tick) <= $signed(req_ff.point_tick))
                       ? kgte_pkg::ST_DONE : kgte_pkg::ST_ADD_READ;
         end
         kgte_pkg::ST_EVAL_READ: state_in = kgte_pkg::ST_EVAL_CMP;
         kgte_pkg::ST_EVAL_CMP: begin
            if (idx_ff == '0) begin
               if (count_ff == CW'(1) || hit) begin
                  state_in = kgte_pkg::ST_DONE;
               end else begin
                  state_in = kgte_pkg::ST_EVAL_READ;
               end
            end else if (hit) begin
               state_in = kgte_pkg::ST_DIV;
            end else if (last_entry) begin
               state_in = kgte_pkg::ST_DONE;
            end else begin
               state_in = kgte_pkg::ST_EVAL_READ;
            end
         end
         kgte_pkg::ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = kgte_pkg::ST_BLEND;
            end
         end
         kgte_pkg::ST_BLEND: state_in = kgte_pkg::ST_DONE;
         kgte_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = kgte_pkg::ST_IDLE;
            end
         end
         default: state_in = kgte_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = (state_ff == kgte_pkg::ST_IDLE);
      req_in        = req_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      prev_tick_in  = prev_tick_ff;
      prev_value_in = prev_value_ff;
      next_value_in = next_value_ff;
      dist_in       = dist_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      track_in      = track_ff;
      rej_in        = rej_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_addr       = idx_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      wr_data.tick  = req_ff.point_tick;
      wr_data.value = req_ff.point_value;

      case (state_ff)
         kgte_pkg::ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               track_in = kgte_pkg::EMPTY_VALUE;
               rej_in   = 1'b0;
               case (req_data.action)
                  kgte_pkg::ACTION_CLEAR: count_in = '0;
                  kgte_pkg::ACTION_ADD: begin
                     rej_in = (count_ff >= MAX_COUNT);
                     idx_in = count_ff;
                  end
                  kgte_pkg::ACTION_EVAL: idx_in = '0;
                  default: ;
               endcase
            end
         end
         kgte_pkg::ST_ADD_READ: begin
            rd_addr = IW'(idx_ff - CW'(1));
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         kgte_pkg::ST_ADD_CMP: begin
            wr_en = 1'b1;
            if ($signed(rd_data_ff.tick) <= $signed(req_ff.point_tick)) begin
               count_in = count_ff + CW'(1);
            end else begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - CW'(1);
            end
         end
         kgte_pkg::ST_EVAL_READ: ;
         kgte_pkg::ST_EVAL_CMP: begin
            if (idx_ff != '0 && hit) begin
               rem_in        = {1'b0, dx_full[31:0]};
               dist_in       = dist_full[31:0];
               next_value_in = rd_data_ff.value;
               quo_in        = '0;
               div_cnt_in    = DCW'(FRACTION_BITS);
            end else if ((idx_ff == '0 && (count_ff == CW'(1) || hit)) || last_entry) begin
               track_in = rd_data_ff.value;
            end else begin
               prev_tick_in  = rd_data_ff.tick;
               prev_value_in = rd_data_ff.value;
               idx_in        = idx_ff + CW'(1);
            end
         end
         kgte_pkg::ST_DIV: begin
            quo_in     = {quo_ff[QW-2:0], rem_ge};
            rem_in     = {rem_sel[31:0], 1'b0};
            div_cnt_in = div_cnt_ff - DCW'(1);
         end
         kgte_pkg::ST_BLEND: track_in = acc_w[FRACTION_BITS+7:FRACTION_BITS];
         kgte_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.track_value  = track_ff;
               rsp_in.add_rejected = rej_ff;
               rsp_in.point_count  = count_wide[5:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kgte_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      prev_tick_ff  <= prev_tick_in;
      prev_value_ff <= prev_value_in;
      next_value_ff <= next_value_in;
      dist_ff       <= dist_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      track_ff      <= track_in;
      rej_ff        <= rej_in;
      rsp_ff        <= rsp_in;
   end

   // point table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("point count above table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == kgte_pkg::ACTION_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the table");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == kgte_pkg::ST_DIV |-> {1'b0, rem_ff} < ({2'b0, dist_ff} << 1))
      else $error("divider remainder out of range");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == kgte_pkg::ST_BLEND |-> quo_ff <= (QW'(1) << FRACTION_BITS))
      else $error("fraction above one");

endmodule
